// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL of the track/sector translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ZDTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one at the same edge.
`define ZDTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/zdts_pkg.sv -----
// Package with shared types and codes of the track/sector translator.
`timescale 1ns / 1ps
package zdts_pkg;

  // Disk format codes
  localparam logic [2:0] FMT_1541 = 3'd0;
  localparam logic [2:0] FMT_1571 = 3'd1;
  localparam logic [2:0] FMT_8050 = 3'd2;
  localparam logic [2:0] FMT_8250 = 3'd3;
  localparam logic [2:0] FMT_1581 = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_TRACK  = 2'd1;
  localparam logic [1:0] STAT_SECTOR = 2'd2;

  // Configuration register indexes
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_TRACKS = 1'b1;

  // Track decode: zone position of one request
  typedef struct packed {
    logic        trk_bad;  // track out of range for image or format
    logic [6:0]  rel;      // track index inside its zone, from 0
    logic [11:0] base;     // first block of the zone, side offset included
    logic [5:0]  cnt;      // sectors per track, zero on a bad track
  } decode_t;

endpackage

// ----- sv/zoned_disk_track_sector_to_offset.sv -----
// Top level of the zoned-disk track/sector to block and byte offset translator.
//
// Takes one request per cycle while the output side does not stall and returns
// one result per request. The result passes through four register stages: track
// decode and zone lookup, zone start multiply, sector check and block add, and
// the byte offset multiply into the output register. Stalls back up through the
// stages without loss; a bubble is filled while the output waits. Configuration
// is taken through a plain write port.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zoned_disk_track_sector_to_offset #(
  parameter int unsigned SECTOR_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  track_number_i,
  input  logic [7:0]  sector_number_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] block_index_o,
  output logic [20:0] byte_offset_o,
  output logic [5:0]  sectors_in_track_o
);

  localparam logic [10:0] SecBytes = 11'(SECTOR_BYTES);

  logic [2:0] format_q;
  logic [7:0] track_count_q;

  zdts_pkg::decode_t dec;
  zdts_pkg::decode_t dec1_q;
  logic [7:0]  sector1_q;
  logic [12:0] start2_q;
  logic [7:0]  sector2_q;
  logic [5:0]  cnt2_q;
  logic        bad2_q;
  logic        secbad2_q;
  logic [1:0]  status3_q;
  logic [12:0] block3_q;
  logic [5:0]  cnt3_q;
  logic [23:0] prod;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        en1, en2, en3, en4;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q      <= 3'd0;
      track_count_q <= 8'd35;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        zdts_pkg::REG_FORMAT: format_q      <= cfg_data_i[2:0];
        zdts_pkg::REG_TRACKS: track_count_q <= cfg_data_i;
        default:              format_q      <= format_q;
      endcase
    end
  end

  zdts_zone u_zone (
    .disk_format_i (format_q),
    .track_count_i (track_count_q),
    .track_i       (track_number_i),
    .dec_o         (dec)
  );

  // Advance a stage when it is empty or its successor moves
  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign prod = 24'(block3_q) * 24'(SecBytes);

  // Data path stages
  always_ff @(posedge clk_i) begin
    // register the decode
    if (en1) begin
      dec1_q    <= dec;
      sector1_q <= sector_number_i;
    end
    // start of the track and sector range check
    if (en2) begin
      start2_q  <= 13'(dec1_q.base) + 13'(dec1_q.rel) * 13'(dec1_q.cnt);
      sector2_q <= sector1_q;
      cnt2_q    <= dec1_q.cnt;
      bad2_q    <= dec1_q.trk_bad;
      secbad2_q <= sector1_q >= {2'b00, dec1_q.cnt};
    end
    // status and block number, zero on error
    if (en3) begin
      cnt3_q <= cnt2_q;
      if (bad2_q) begin
        status3_q <= zdts_pkg::STAT_TRACK;
        block3_q  <= 13'd0;
      end else if (secbad2_q) begin
        status3_q <= zdts_pkg::STAT_SECTOR;
        block3_q  <= 13'd0;
      end else begin
        status3_q <= zdts_pkg::STAT_OK;
        block3_q  <= start2_q + 13'(sector2_q);
      end
    end
    // byte offset and output register
    if (en4) begin
      status_o           <= status3_q;
      block_index_o      <= block3_q;
      byte_offset_o      <= prod[20:0];
      sectors_in_track_o <= cnt3_q;
    end
  end

  // Checks
  `ZDTS_ASSERT_IMP(a_err_zero, valid_o && (status_o != zdts_pkg::STAT_OK), (block_index_o == 13'd0) && (byte_offset_o == 21'd0), "error result carries nonzero address")
  `ZDTS_ASSERT_IMP(a_trk_cnt, valid_o && (status_o == zdts_pkg::STAT_TRACK), sectors_in_track_o == 6'd0, "bad track reports a sector count")
  `ZDTS_ASSERT_IMP(a_ok_cnt, valid_o && (status_o == zdts_pkg::STAT_OK), (sectors_in_track_o != 6'd0) && (sectors_in_track_o <= 6'd40), "good result has bad sector count")
  `ZDTS_ASSERT_IMP(a_no_bubble_stall, !ready_o, v1_q && v2_q && v3_q && v4_q, "input stalled with an empty stage")

endmodule

// ----- sv/zdts_zone.sv -----
// Track range check and speed zone lookup.
`timescale 1ns / 1ps
module zdts_zone (
  input  logic [2:0]       disk_format_i,
  input  logic [7:0]       track_count_i,
  input  logic [7:0]       track_i,
  output zdts_pkg::decode_t dec_o
);

  logic [7:0]  max_trk;
  logic [7:0]  side_len;
  logic [11:0] side_base;
  logic        second;
  logic [7:0]  t_loc;
  logic [7:0]  prev_end;
  logic [11:0] acc;
  logic [5:0]  cnt;
  logic        bad;

  // Format limits and side layout
  always_comb begin
    max_trk   = 8'd0;
    side_len  = 8'd0;
    side_base = 12'd0;
    case (disk_format_i)
      zdts_pkg::FMT_1541: begin
        max_trk  = 8'd40;
        side_len = 8'd40;
      end
      zdts_pkg::FMT_1571: begin
        max_trk   = 8'd70;
        side_len  = 8'd35;
        side_base = 12'd683;
      end
      zdts_pkg::FMT_8050: begin
        max_trk  = 8'd77;
        side_len = 8'd77;
      end
      zdts_pkg::FMT_8250: begin
        max_trk   = 8'd154;
        side_len  = 8'd77;
        side_base = 12'd2083;
      end
      zdts_pkg::FMT_1581: begin
        max_trk  = 8'd80;
        side_len = 8'd80;
      end
      default: begin
        max_trk = 8'd0;
      end
    endcase
  end

  assign bad    = (track_i == 8'd0) || (track_i > track_count_i) || (track_i > max_trk);
  assign second = (track_i > side_len);
  assign t_loc  = second ? track_i - side_len : track_i;

  // Pick the zone of the track within its side
  always_comb begin
    prev_end = 8'd0;
    acc      = 12'd0;
    cnt      = 6'd0;
    case (disk_format_i)
      zdts_pkg::FMT_1541, zdts_pkg::FMT_1571: begin
        if (t_loc <= 8'd17) begin
          cnt = 6'd21;
        end else if (t_loc <= 8'd24) begin
          prev_end = 8'd17; acc = 12'd357; cnt = 6'd19;
        end else if (t_loc <= 8'd30) begin
          prev_end = 8'd24; acc = 12'd490; cnt = 6'd18;
        end else begin
          prev_end = 8'd30; acc = 12'd598; cnt = 6'd17;
        end
      end
      zdts_pkg::FMT_8050, zdts_pkg::FMT_8250: begin
        if (t_loc <= 8'd39) begin
          cnt = 6'd29;
        end else if (t_loc <= 8'd53) begin
          prev_end = 8'd39; acc = 12'd1131; cnt = 6'd27;
        end else if (t_loc <= 8'd64) begin
          prev_end = 8'd53; acc = 12'd1509; cnt = 6'd25;
        end else begin
          prev_end = 8'd64; acc = 12'd1784; cnt = 6'd23;
        end
      end
      zdts_pkg::FMT_1581: begin
        cnt = 6'd40;
      end
      default: begin
        cnt = 6'd0;
      end
    endcase
  end

  // Pack the decode, zeroing the count on a bad track
  always_comb begin
    dec_o.trk_bad = bad;
    dec_o.rel     = 7'(t_loc - prev_end - 8'd1);
    dec_o.base    = (second ? side_base : 12'd0) + acc;
    dec_o.cnt     = bad ? 6'd0 : cnt;
  end

endmodule
